// ===== hdl/mpdb_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and helpers for the multi-pin debounce and pulse timer
// no dependencies

package mpdb_pkg;

  localparam int PinCount  = 32;
  localparam int Slots     = 32;
  localparam int WalkCount = (PinCount < Slots) ? PinCount : Slots;
  localparam int IdxW      = $clog2(Slots);
  localparam int CntW      = IdxW + 1;

  localparam logic [31:0] NoDeadline = 32'hFFFF_FFFF;

  localparam int InDataW  = 104;
  localparam int OutDataW = 40;
  localparam int AddrW    = 4;

  typedef enum logic [1:0] {
    REG_INPUT_MASK  = 2'd0,
    REG_OUTPUT_MASK = 2'd1,
    REG_ACTIVE_HIGH = 2'd2,
    REG_SETTLE      = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    FUNC_TICK     = 2'd0,
    FUNC_PULSE    = 2'd1,
    FUNC_INACTIVE = 2'd2,
    FUNC_SET      = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    PH_WAIT_ACTIVE     = 2'd0,
    PH_SETTLE_ACTIVE   = 2'd1,
    PH_WAIT_INACTIVE   = 2'd2,
    PH_SETTLE_INACTIVE = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_ACTIVATED   = 2'd0,
    KIND_DEACTIVATED = 2'd1,
    KIND_NONE        = 2'd2
  } kind_e;

  typedef struct packed {
    phase_e      phase;
    logic [31:0] mark;
  } cell_state_t;

  typedef struct packed {
    logic        valid;
    func_e       func;
    logic        hit;
    logic        level;
    logic        act;
    logic        in_en;
    logic        out_en;
    logic        want;
    logic [31:0] now;
    logic [31:0] dur;
    logic [15:0] settle;
  } head_ctrl_t;

  typedef struct packed {
    logic  drv_we;
    logic  drv_val;
    logic  ev;
    kind_e ev_kind;
  } head_stat_t;

  function automatic logic [IdxW-1:0] first_set(input logic [Slots-1:0] v);
    logic [IdxW-1:0] idx;
    idx = '0;
    for (int i = Slots - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = IdxW'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== hdl/multi_pin_debounce_and_pulse_timer.sv =====
`timescale 1ns / 1ps
// multi-pin debounce and pulse timer: ring of 32 pin cells rotated past one update unit
// each item walks the ring past the head, then its results go out (events, then closing)
// at one per cycle while the output side does not stall
// the item is captured on transfer; a new item is taken once the closing result is loaded
// reset: asynchronous, active low; clears config registers, cell state, drive levels and control
// depends on mpdb_pkg, mpdb_cell, mpdb_head

module multi_pin_debounce_and_pulse_timer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mpdb_pkg::AddrW-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // pin_levels[31:0], now_ms[63:32], pin[68:64], duration_ms[100:69], drive_active[101]
  input  logic [mpdb_pkg::InDataW-1:0]  s_axis_tdata,
  // func[1:0]
  input  logic [1:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // event_pin[4:0], drive_levels[36:5]
  output logic [mpdb_pkg::OutDataW-1:0] m_axis_tdata,
  // event_kind[1:0]
  output logic [1:0]                    m_axis_tuser,
  output logic                          m_axis_tlast
);

  localparam int Slots = mpdb_pkg::Slots;
  localparam int IdxW  = mpdb_pkg::IdxW;
  localparam int CntW  = mpdb_pkg::CntW;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [31:0] in_mask_q, out_mask_q, act_mask_q;
  logic [15:0] settle_q;
  logic [31:0] drive_q, drive_d;

  mpdb_pkg::func_e func_q;
  logic [31:0]     levels_q, now_q, dur_q;
  logic [IdxW-1:0] pin_q;
  logic            want_q;

  logic [IdxW-1:0]  k_q, k_d;
  logic [Slots-1:0] pend_q, pend_d, deact_q, deact_d;

  logic                   ov_q, ov_d;
  logic [IdxW-1:0]        opin_q, opin_d;
  mpdb_pkg::kind_e        okind_q, okind_d;
  logic [31:0]            olev_q, olev_d;
  logic                   olast_q, olast_d;

  logic             cfg_we;
  logic             in_xfer;
  logic             out_free;
  logic             shift;
  logic [Slots-1:0] clear;
  logic [31:0]      changed;

  mpdb_pkg::cell_state_t cell_st [Slots];
  mpdb_pkg::cell_state_t head_nxt;
  mpdb_pkg::cell_state_t ring_in;
  mpdb_pkg::head_ctrl_t  hctrl;
  mpdb_pkg::head_stat_t  hstat;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;

  always_comb begin
    case (mpdb_pkg::reg_e'(paddr[3:2]))
      mpdb_pkg::REG_INPUT_MASK:  prdata = in_mask_q;
      mpdb_pkg::REG_OUTPUT_MASK: prdata = out_mask_q;
      mpdb_pkg::REG_ACTIVE_HIGH: prdata = act_mask_q;
      default:                   prdata = {16'd0, settle_q};
    endcase
  end

  always_comb begin
    changed = '0;
    if (cfg_we) begin
      case (mpdb_pkg::reg_e'(paddr[3:2]))
        mpdb_pkg::REG_INPUT_MASK:  changed = in_mask_q ^ pwdata;
        mpdb_pkg::REG_OUTPUT_MASK: changed = out_mask_q ^ pwdata;
        default:                   changed = '0;
      endcase
    end
  end

  assign clear = changed[Slots-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_mask_q  <= '0;
      out_mask_q <= '0;
      act_mask_q <= '0;
      settle_q   <= '0;
    end else if (cfg_we) begin
      case (mpdb_pkg::reg_e'(paddr[3:2]))
        mpdb_pkg::REG_INPUT_MASK:  in_mask_q  <= pwdata;
        mpdb_pkg::REG_OUTPUT_MASK: out_mask_q <= pwdata;
        mpdb_pkg::REG_ACTIVE_HIGH: act_mask_q <= pwdata;
        default:                   settle_q   <= pwdata[15:0];
      endcase
    end
  end

  // state ring: cell 0 feeds the head, the head feeds the last cell
  assign shift   = (state_q == ST_WALK);
  assign ring_in = hctrl.valid ? head_nxt : cell_st[0];

  for (genvar i = 0; i < Slots; i++) begin : g_cell
    if (i == Slots - 1) begin : g_tail
      mpdb_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift),
        .clear_i (clear[i]),
        .nbr_i   (ring_in),
        .state_o (cell_st[i])
      );
    end else begin : g_body
      mpdb_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift),
        .clear_i (clear[i]),
        .nbr_i   (cell_st[i+1]),
        .state_o (cell_st[i])
      );
    end
  end

  always_comb begin
    hctrl.valid  = shift && ({1'b0, k_q} < CntW'(mpdb_pkg::WalkCount));
    hctrl.func   = func_q;
    hctrl.hit    = (k_q == pin_q);
    hctrl.level  = levels_q[k_q];
    hctrl.act    = act_mask_q[k_q];
    hctrl.in_en  = in_mask_q[k_q];
    hctrl.out_en = out_mask_q[k_q];
    hctrl.want   = want_q;
    hctrl.now    = now_q;
    hctrl.dur    = dur_q;
    hctrl.settle = settle_q;
  end

  mpdb_head u_head (
    .cur_i  (cell_st[0]),
    .ctrl_i (hctrl),
    .nxt_o  (head_nxt),
    .stat_o (hstat)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !ov_q || m_axis_tready;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      func_q   <= mpdb_pkg::func_e'(s_axis_tuser);
      levels_q <= s_axis_tdata[31:0];
      now_q    <= s_axis_tdata[63:32];
      pin_q    <= s_axis_tdata[68:64];
      dur_q    <= s_axis_tdata[100:69];
      want_q   <= s_axis_tdata[101];
    end
  end

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    pend_d  = pend_q;
    deact_d = deact_q;
    drive_d = drive_q;
    ov_d    = ov_q && !m_axis_tready;
    opin_d  = opin_q;
    okind_d = okind_q;
    olev_d  = olev_q;
    olast_d = olast_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          k_d     = '0;
          pend_d  = '0;
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (hstat.drv_we) begin
          drive_d[k_q] = hstat.drv_val;
        end
        if (hstat.ev) begin
          pend_d[k_q]  = 1'b1;
          deact_d[k_q] = (hstat.ev_kind == mpdb_pkg::KIND_DEACTIVATED);
        end
        k_d = k_q + 1'b1;
        if (k_q == IdxW'(Slots - 1)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          ov_d   = 1'b1;
          olev_d = drive_q;
          if (pend_q != '0) begin
            opin_d          = mpdb_pkg::first_set(pend_q);
            okind_d         = deact_q[opin_d] ? mpdb_pkg::KIND_DEACTIVATED :
                                                mpdb_pkg::KIND_ACTIVATED;
            olast_d         = 1'b0;
            pend_d[opin_d]  = 1'b0;
          end else begin
            opin_d  = '0;
            okind_d = mpdb_pkg::KIND_NONE;
            olast_d = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      pend_q  <= '0;
      drive_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      pend_q  <= pend_d;
      drive_q <= drive_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    deact_q <= deact_d;
    opin_q  <= opin_d;
    okind_q <= okind_d;
    olev_q  <= olev_d;
    olast_q <= olast_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {3'd0, olev_q, opin_q};
  assign m_axis_tuser  = okind_q;
  assign m_axis_tlast  = olast_q;

endmodule

// ===== hdl/mpdb_cell.sv =====
`timescale 1ns / 1ps
// one pin slot of the rotating state ring: debounce phase and mark time
// depends on mpdb_pkg

module mpdb_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  shift_i,
  input  logic                  clear_i,
  input  mpdb_pkg::cell_state_t nbr_i,
  output mpdb_pkg::cell_state_t state_o
);

  mpdb_pkg::cell_state_t state_q, state_d;

  always_comb begin
    state_d = state_q;
    if (shift_i) begin
      state_d = nbr_i;
    end else if (clear_i) begin
      state_d.phase = mpdb_pkg::PH_WAIT_ACTIVE;
      state_d.mark  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase <= mpdb_pkg::PH_WAIT_ACTIVE;
      state_q.mark  <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule

// ===== hdl/mpdb_head.sv =====
`timescale 1ns / 1ps
// update unit at the head of the ring: debounce step, deadline expiry and drive commands
// depends on mpdb_pkg

module mpdb_head (
  input  mpdb_pkg::cell_state_t cur_i,
  input  mpdb_pkg::head_ctrl_t  ctrl_i,
  output mpdb_pkg::cell_state_t nxt_o,
  output mpdb_pkg::head_stat_t  stat_o
);

  logic        is_act;
  logic        settled;
  logic [31:0] elapsed;

  assign is_act  = (ctrl_i.level == ctrl_i.act);
  assign elapsed = ctrl_i.now - cur_i.mark;
  assign settled = (elapsed >= {16'd0, ctrl_i.settle});

  always_comb begin
    nxt_o          = cur_i;
    stat_o.drv_we  = 1'b0;
    stat_o.drv_val = 1'b0;
    stat_o.ev      = 1'b0;
    stat_o.ev_kind = mpdb_pkg::KIND_ACTIVATED;
    if (ctrl_i.valid) begin
      if (ctrl_i.func == mpdb_pkg::FUNC_TICK) begin
        if (ctrl_i.in_en) begin
          case (cur_i.phase)
            mpdb_pkg::PH_WAIT_ACTIVE: begin
              if (is_act) begin
                nxt_o.mark  = ctrl_i.now;
                nxt_o.phase = mpdb_pkg::PH_SETTLE_ACTIVE;
              end
            end
            mpdb_pkg::PH_SETTLE_ACTIVE: begin
              if (settled) begin
                nxt_o.phase    = mpdb_pkg::PH_WAIT_INACTIVE;
                stat_o.ev      = 1'b1;
                stat_o.ev_kind = mpdb_pkg::KIND_ACTIVATED;
              end else if (!is_act) begin
                nxt_o.phase = mpdb_pkg::PH_WAIT_ACTIVE;
              end
            end
            mpdb_pkg::PH_WAIT_INACTIVE: begin
              if (!is_act) begin
                nxt_o.mark  = ctrl_i.now;
                nxt_o.phase = mpdb_pkg::PH_SETTLE_INACTIVE;
              end
            end
            default: begin
              if (settled) begin
                nxt_o.phase    = mpdb_pkg::PH_WAIT_ACTIVE;
                stat_o.ev      = 1'b1;
                stat_o.ev_kind = mpdb_pkg::KIND_DEACTIVATED;
              end else if (is_act) begin
                nxt_o.phase = mpdb_pkg::PH_WAIT_INACTIVE;
              end
            end
          endcase
        end else if (ctrl_i.out_en) begin
          if ((cur_i.mark != '0) && (ctrl_i.now >= cur_i.mark)) begin
            nxt_o.mark     = '0;
            stat_o.drv_we  = 1'b1;
            stat_o.drv_val = !ctrl_i.act;
          end
        end
      end else if (ctrl_i.hit) begin
        stat_o.drv_we = 1'b1;
        case (ctrl_i.func)
          mpdb_pkg::FUNC_PULSE: begin
            stat_o.drv_val = ctrl_i.act;
            nxt_o.mark     = (ctrl_i.dur != mpdb_pkg::NoDeadline) ?
                             (ctrl_i.now + ctrl_i.dur) : '0;
          end
          mpdb_pkg::FUNC_INACTIVE: begin
            stat_o.drv_val = !ctrl_i.act;
            nxt_o.mark     = '0;
          end
          default: begin
            stat_o.drv_val = ctrl_i.want ? ctrl_i.act : !ctrl_i.act;
            nxt_o.mark     = '0;
          end
        endcase
      end
    end
  end

endmodule

// ===== bench/tb_multi_pin_debounce_and_pulse_timer.sv =====
`timescale 1ns / 1ps
// self-checking bench for the multi-pin debounce and pulse timer: tick and drive command
// transfers in bursts, register settings over apb, results checked against a scoreboard
// depends on mpdb_pkg and multi_pin_debounce_and_pulse_timer

import mpdb_pkg::*;

typedef struct packed {
  logic [4:0]  pin;
  kind_e       kind;
  logic [31:0] drive;
  logic        last;
} pin_result_t;

class debounce_scoreboard;
  logic [31:0]   in_mask;
  logic [31:0]   out_mask;
  logic [31:0]   act_mask;
  logic [15:0]   settle;
  phase_e        phase [Slots];
  logic [31:0]   mark [Slots];
  logic [31:0]   drive;
  pin_result_t   expected_q [$];
  int unsigned   mismatches;
  int unsigned   items_seen;
  int unsigned   ticks_seen;
  int unsigned   events_seen;
  int unsigned   results_seen;

  function new();
    in_mask      = '0;
    out_mask     = '0;
    act_mask     = '0;
    settle       = '0;
    drive        = '0;
    mismatches   = 0;
    items_seen   = 0;
    ticks_seen   = 0;
    events_seen  = 0;
    results_seen = 0;
    for (int p = 0; p < Slots; p++) begin
      phase[p] = PH_WAIT_ACTIVE;
      mark[p]  = '0;
    end
  endfunction

  function void clear_changed(logic [31:0] changed);
    for (int p = 0; p < Slots; p++) begin
      if (changed[p]) begin
        phase[p] = PH_WAIT_ACTIVE;
        mark[p]  = '0;
      end
    end
  endfunction

  function void write_reg(reg_e idx, logic [31:0] v);
    case (idx)
      REG_INPUT_MASK: begin
        clear_changed(in_mask ^ v);
        in_mask = v;
      end
      REG_OUTPUT_MASK: begin
        clear_changed(out_mask ^ v);
        out_mask = v;
      end
      REG_ACTIVE_HIGH: act_mask = v;
      default:         settle = v[15:0];
    endcase
  endfunction

  function void note_item(func_e f, logic [31:0] lv, logic [31:0] now, logic [4:0] pin,
                          logic [31:0] dur, logic want);
    logic [4:0]  ev_pin [$];
    kind_e       ev_kind [$];
    logic        act;
    logic        is_act;
    logic        settled;
    pin_result_t r;
    items_seen++;
    if (f == FUNC_TICK) begin
      ticks_seen++;
      for (int p = 0; p < WalkCount; p++) begin
        act = act_mask[p];
        if (in_mask[p]) begin
          is_act  = (lv[p] == act);
          settled = (now - mark[p]) >= 32'(settle);
          case (phase[p])
            PH_WAIT_ACTIVE: begin
              if (is_act) begin
                mark[p]  = now;
                phase[p] = PH_SETTLE_ACTIVE;
              end
            end
            PH_SETTLE_ACTIVE: begin
              if (settled) begin
                phase[p] = PH_WAIT_INACTIVE;
                ev_pin.push_back(5'(p));
                ev_kind.push_back(KIND_ACTIVATED);
              end else if (!is_act) begin
                phase[p] = PH_WAIT_ACTIVE;
              end
            end
            PH_WAIT_INACTIVE: begin
              if (!is_act) begin
                mark[p]  = now;
                phase[p] = PH_SETTLE_INACTIVE;
              end
            end
            default: begin
              if (settled) begin
                phase[p] = PH_WAIT_ACTIVE;
                ev_pin.push_back(5'(p));
                ev_kind.push_back(KIND_DEACTIVATED);
              end else if (is_act) begin
                phase[p] = PH_WAIT_INACTIVE;
              end
            end
          endcase
        end else if (out_mask[p]) begin
          if (mark[p] != '0 && now >= mark[p]) begin
            mark[p]  = '0;
            drive[p] = !act;
          end
        end
      end
    end else if (int'(pin) < WalkCount) begin
      act = act_mask[pin];
      case (f)
        FUNC_PULSE: begin
          drive[pin] = act;
          mark[pin]  = (dur != NoDeadline) ? now + dur : '0;
        end
        FUNC_INACTIVE: begin
          drive[pin] = !act;
          mark[pin]  = '0;
        end
        default: begin
          drive[pin] = want ? act : !act;
          mark[pin]  = '0;
        end
      endcase
    end
    foreach (ev_pin[i]) begin
      r = '{pin: ev_pin[i], kind: ev_kind[i], drive: drive, last: 1'b0};
      expected_q.push_back(r);
    end
    events_seen += ev_pin.size();
    r = '{pin: 5'd0, kind: KIND_NONE, drive: drive, last: 1'b1};
    expected_q.push_back(r);
  endfunction

  function void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endfunction

  function void check_result(logic [4:0] pin, logic [1:0] kind, logic [31:0] drv,
                             logic last);
    pin_result_t r;
    results_seen++;
    if (expected_q.size() == 0) begin
      note_mismatch($sformatf("unexpected result pin %0d kind %0d drive %h last %b",
                              pin, kind, drv, last));
      return;
    end
    r = expected_q.pop_front();
    if (r.pin !== pin || r.kind !== kind || r.drive !== drv || r.last !== last) begin
      note_mismatch($sformatf("exp pin %0d kind %0d drive %h last %b, got %0d %0d %h %b",
                              r.pin, r.kind, r.drive, r.last, pin, kind, drv, last));
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb_multi_pin_debounce_and_pulse_timer;

  localparam int IdleLimit = 3000;
  localparam int TailCycles = 80;

  typedef enum int {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_PERIODIC,
    RDY_SPARSE
  } ready_mode_e;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [AddrW-1:0]    paddr         = '0;
  logic [31:0]         pwdata        = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // pin_levels[31:0], now_ms[63:32], pin[68:64], duration_ms[100:69], drive_active[101]
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  // func[1:0]
  logic [1:0]          s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // event_pin[4:0], drive_levels[36:5]
  logic [OutDataW-1:0] m_axis_tdata;
  // event_kind[1:0]
  logic [1:0]          m_axis_tuser;
  logic                m_axis_tlast;

  debounce_scoreboard sb = new();
  int unsigned burst_left = 1;
  int unsigned reg_writes = 0;

  multi_pin_debounce_and_pulse_timer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic reg_write(reg_e idx, logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(idx, v);
    reg_writes++;
    @(posedge clk_i);
  endtask

  task automatic set_regs(logic [31:0] in_m, logic [31:0] out_m, logic [31:0] act_m,
                          logic [15:0] settle);
    reg_write(REG_INPUT_MASK, in_m);
    reg_write(REG_OUTPUT_MASK, out_m);
    reg_write(REG_ACTIVE_HIGH, act_m);
    reg_write(REG_SETTLE, {16'd0, settle});
  endtask

  task automatic send_item(func_e f, logic [31:0] lv, logic [31:0] now, logic [4:0] pin,
                           logic [31:0] dur, logic want);
    s_axis_tuser  <= f;
    s_axis_tdata  <= {2'b00, want, dur, pin, now, lv};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(f, lv, now, pin, dur, want);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
    end
  endtask

  // stop sending and hold off until every expected result has been transferred
  task automatic drain();
    if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // result side: check each transfer, then pick the next ready level
  initial begin
    ready_mode_e mode;
    int unsigned stretch_left;
    int unsigned period;
    int unsigned cnt;
    mode         = RDY_ALWAYS;
    stretch_left = 0;
    period       = 2;
    cnt          = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tdata[4:0], m_axis_tuser, m_axis_tdata[36:5], m_axis_tlast);
      end
      if (stretch_left == 0) begin
        mode         = ready_mode_e'($urandom_range(0, 3));
        stretch_left = $urandom_range(20, 200);
        period       = $urandom_range(2, 9);
      end
      stretch_left--;
      cnt++;
      case (mode)
        RDY_ALWAYS:   m_axis_tready <= 1'b1;
        RDY_COIN:     m_axis_tready <= 1'($urandom_range(0, 1));
        RDY_PERIODIC: m_axis_tready <= (cnt % period) != 0;
        default:      m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("timeout: no transfer for %0d cycles", IdleLimit);
    $display("tb_multi_pin_debounce_and_pulse_timer: FAIL");
    $finish;
  end

  initial begin
    logic [31:0] t;
    logic [31:0] lv;
    logic [31:0] span;
    logic [31:0] dur;
    logic [31:0] in_m;
    int unsigned roll;
    int unsigned fails;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: pins 0 and 7 are in both masks, 24..31 outputs, 12 unused
    set_regs(32'h0000_00FF, 32'hFF00_0081, 32'hA5A5_A5A5, 16'd5);
    send_item(FUNC_TICK, 32'h0000_0000, 32'd100, 5'd0, 32'd0, 1'b0);
    send_item(FUNC_TICK, 32'hFFFF_FFFF, 32'd102, 5'd0, 32'd0, 1'b0);
    send_item(FUNC_TICK, 32'hFFFF_FFFF, 32'd110, 5'd0, 32'd0, 1'b0);
    send_item(FUNC_PULSE, 32'd0, 32'd110, 5'd24, 32'd10, 1'b0);
    send_item(FUNC_PULSE, 32'd0, 32'd110, 5'd25, NoDeadline, 1'b0);
    // deadline wraps to zero, so no deadline
    send_item(FUNC_PULSE, 32'd0, 32'd110, 5'd26, 32'hFFFF_FF92, 1'b0);
    send_item(FUNC_PULSE, 32'd0, 32'd200, 5'd27, 32'd0, 1'b0);
    send_item(FUNC_INACTIVE, 32'd0, 32'd110, 5'd28, 32'd0, 1'b0);
    send_item(FUNC_SET, 32'd0, 32'd110, 5'd29, 32'd0, 1'b1);
    send_item(FUNC_SET, 32'd0, 32'd110, 5'd30, 32'd0, 1'b0);
    // command to an input pin and to an unused pin
    send_item(FUNC_SET, 32'd0, 32'd110, 5'd3, 32'd0, 1'b1);
    send_item(FUNC_PULSE, 32'd0, 32'd110, 5'd12, 32'd5, 1'b1);
    // deadline wraps past zero and is compared without wrapping
    send_item(FUNC_PULSE, 32'd0, 32'hFFFF_FFF0, 5'd31, 32'h0000_0020, 1'b0);
    send_item(FUNC_TICK, 32'h0000_0000, 32'd120, 5'd0, 32'd0, 1'b0);
    send_item(FUNC_TICK, 32'h0000_0000, 32'd200, 5'd0, 32'd0, 1'b0);
    send_item(FUNC_TICK, 32'h0000_0000, 32'hFFFF_FFFE, 5'd0, 32'd0, 1'b0);
    send_item(FUNC_TICK, 32'h0000_005A, 32'd3, 5'd0, 32'd0, 1'b0);
    send_item(FUNC_TICK, 32'h0000_005A, 32'd10, 5'd0, 32'd0, 1'b0);
    drain();
    set_regs(32'h0000_00FF, 32'hFF00_0081, 32'hA5A5_A5A5, 16'd0);
    send_item(FUNC_TICK, 32'hFFFF_FFFF, 32'd0, 5'd0, 32'd0, 1'b0);
    send_item(FUNC_TICK, 32'hFFFF_FFFF, 32'd0, 5'd0, 32'd0, 1'b0);
    drain();
    set_regs(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(FUNC_TICK, 32'hFFFF_FFFF, 32'd0, 5'd0, 32'd0, 1'b0);
    send_item(FUNC_TICK, 32'hFFFF_FFFF, 32'd65534, 5'd0, 32'd0, 1'b0);
    send_item(FUNC_TICK, 32'hFFFF_FFFF, 32'd65535, 5'd0, 32'd0, 1'b0);
    drain();

    // random phases: mostly advancing time with sparse level flips, some commands and noise
    for (int k = 0; k < 6; k++) begin
      case (k)
        0: set_regs($urandom, $urandom, $urandom, 16'($urandom_range(1, 20)));
        1: set_regs(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 16'd0);
        2: set_regs(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        3: begin
          in_m = $urandom & $urandom;
          set_regs(in_m, ~in_m, $urandom, 16'($urandom_range(0, 65535)));
        end
        default: set_regs($urandom, $urandom, $urandom, 16'($urandom_range(1, 8)));
      endcase
      t    = $urandom;
      lv   = $urandom;
      span = 32'(sb.settle) + 32'(sb.settle >> 1) + 32'd2;
      for (int i = 0; i < 13; i++) begin
        roll = $urandom_range(0, 99);
        if (k == 5 || roll < 10) begin
          send_item(func_e'($urandom_range(0, 3)), $urandom, $urandom,
                    5'($urandom_range(0, 31)), $urandom, 1'($urandom_range(0, 1)));
        end else if (roll < 35) begin
          case ($urandom_range(0, 2))
            0:       dur = NoDeadline;
            1:       dur = $urandom;
            default: dur = $urandom_range(0, 2 * span);
          endcase
          send_item(func_e'($urandom_range(1, 3)), lv, t, 5'($urandom_range(0, 31)), dur,
                    1'($urandom_range(0, 1)));
        end else begin
          t  = t + $urandom_range(0, span);
          lv = lv ^ ($urandom & $urandom & $urandom);
          send_item(FUNC_TICK, lv, t, 5'($urandom_range(0, 31)), $urandom,
                    1'($urandom_range(0, 1)));
        end
        if (k == 0 && i == 8) drain();
      end
      drain();
    end

    repeat (TailCycles) @(posedge clk_i);
    fails = sb.mismatches + sb.pending();
    $display("covered %0d items (%0d ticks), %0d events, %0d results, %0d register writes",
             sb.items_seen, sb.ticks_seen, sb.events_seen, sb.results_seen, reg_writes);
    $display("mismatches %0d, results still expected %0d", sb.mismatches, sb.pending());
    if (fails == 0) begin
      $display("tb_multi_pin_debounce_and_pulse_timer: PASS");
    end else begin
      $display("tb_multi_pin_debounce_and_pulse_timer: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/mpdb_pkg.sv
hdl/mpdb_cell.sv
hdl/mpdb_head.sv
hdl/multi_pin_debounce_and_pulse_timer.sv
bench/tb_multi_pin_debounce_and_pulse_timer.sv
